// ===== rtl/drbe_pkg.sv =====
// Shared types and constants for the report-by-exception deadband filter.
// No dependencies; imported by drbe_band and deadband_report_by_exception.
package drbe_pkg;

  localparam int unsigned CHANNELS      = 16;
  localparam int unsigned SAMPLE_BITS   = 32;
  localparam int unsigned CH_BITS       = 4;
  localparam int unsigned IDX_BITS      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DIFF_BITS     = SAMPLE_BITS + 1;
  localparam int unsigned BAND_BITS     = 24;
  localparam int unsigned FRAC_BITS     = 8;
  localparam int unsigned PROD_BITS     = SAMPLE_BITS + BAND_BITS;
  // percent band: 100 percent times 2^FRAC_BITS
  localparam int unsigned PCT_SCALE     = 100 * (1 << FRAC_BITS);
  localparam int unsigned PCT_BITS      = 15;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  typedef enum logic [2:0] {
    MODE_CHANGE       = 3'd0,
    MODE_CHANGE_QUIET = 3'd1,
    MODE_OUT_GE       = 3'd2,
    MODE_OUT_GT       = 3'd3,
    MODE_IN_LT        = 3'd4,
    MODE_IN_LE        = 3'd5
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FILTER_MODE  = 3'd0,
    REG_REF_SOURCE   = 3'd1,
    REG_BAND_WIDTH   = 3'd2,
    REG_BAND_PERCENT = 3'd3,
    REG_START_VALUE  = 3'd4,
    REG_START_ENABLE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic                 percent;
    logic [BAND_BITS-1:0] width;
  } band_cfg_t;

  typedef struct packed {
    logic lt;
    logic gt;
  } band_cmp_t;

endpackage

// ===== rtl/drbe_band.sv =====
// Deadband compare: scales distance and band, registers both sides, compares.
// Depends on drbe_pkg.
module drbe_band (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  drbe_pkg::band_cfg_t                 band_cfg_i,
  input  logic [drbe_pkg::DIFF_BITS-1:0]      diff_i,
  input  logic [drbe_pkg::SAMPLE_BITS-1:0]    ref_abs_i,
  output drbe_pkg::band_cmp_t                 cmp_o
);
  import drbe_pkg::*;

  logic [DIFF_BITS+PCT_BITS-1:0] lhs_pct;
  logic [PROD_BITS-1:0]          rhs_pct;
  logic [PROD_BITS-1:0]          lhs_d, lhs_q;
  logic [PROD_BITS-1:0]          rhs_d, rhs_q;

  assign lhs_pct = diff_i * PCT_BITS'(PCT_SCALE);
  assign rhs_pct = ref_abs_i * band_cfg_i.width;

  always_comb begin
    if (band_cfg_i.percent) begin
      lhs_d = PROD_BITS'(lhs_pct);
      rhs_d = rhs_pct;
    end else begin
      lhs_d = PROD_BITS'({diff_i, {FRAC_BITS{1'b0}}});
      rhs_d = PROD_BITS'(band_cfg_i.width);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
    end
  end

  assign cmp_o.lt = (lhs_q < rhs_q);
  assign cmp_o.gt = (lhs_q > rhs_q);

endmodule

// ===== rtl/deadband_report_by_exception.sv =====
// Report-by-exception deadband filter, one reference per channel in a RAM.
// A passing sample crosses the stage registers and the output register. One sample
// per cycle is taken unless the output holds; in the band modes with last-passed
// reference a sample waits while an older sample of the same channel is in flight.
// Reset clears config registers and all channel valid bits; RAM contents are not
// cleared, an unset channel never reads its entry. Depends on drbe_pkg, drbe_band.
module deadband_report_by_exception (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [drbe_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [drbe_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [drbe_pkg::CH_BITS-1:0]            channel_i,
  input  logic signed [drbe_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [drbe_pkg::CH_BITS-1:0]            out_channel_o,
  output logic signed [drbe_pkg::SAMPLE_BITS-1:0] out_sample_o
);
  import drbe_pkg::*;

  // configuration
  logic [2:0]                  mode_q;
  logic                        src_q;
  logic [BAND_BITS-1:0]        band_q;
  logic                        pct_q;
  logic signed [31:0]          start_q;
  logic                        start_en_q;
  logic signed [SAMPLE_BITS-1:0] start_w;

  logic mode_ok, late_mode, inside_mode;

  // channel state
  logic [CHANNELS-1:0]         valid_q;
  logic [SAMPLE_BITS-1:0]      ref_mem [CHANNELS];
  logic [SAMPLE_BITS-1:0]      rd_q;

  // input side
  logic [IDX_BITS-1:0]         in_idx;
  logic                        in_range, hazard, advance, accept, live;
  logic                        was_valid, preload;

  // stage 1
  logic                        v1_q, first1_q, pre1_q;
  logic [CH_BITS-1:0]          ch1_q;
  logic signed [SAMPLE_BITS-1:0] s1_q;
  logic signed [SAMPLE_BITS-1:0] fwd1, ref1;
  logic signed [DIFF_BITS-1:0] sx1, rx1;
  logic [DIFF_BITS-1:0]        diff1;
  logic [SAMPLE_BITS-1:0]      rabs1;

  // stage 2
  logic                        v2_q, first2_q, pre2_q, zero2_q;
  logic [CH_BITS-1:0]          ch2_q;
  logic signed [SAMPLE_BITS-1:0] s2_q;
  logic [DIFF_BITS-1:0]        diff2_q;
  logic [SAMPLE_BITS-1:0]      rabs2_q;

  // stage 3
  logic                        v3_q, first3_q, pre3_q, zero3_q;
  logic [CH_BITS-1:0]          ch3_q;
  logic signed [SAMPLE_BITS-1:0] s3_q;
  band_cmp_t                   cmp3;
  band_cfg_t                   band_cfg;
  logic                        pass3, we;
  logic [SAMPLE_BITS-1:0]      wdata;

  // last write, for the read issued at the same edge
  logic                        wv_q;
  logic [CH_BITS-1:0]          wch_q;
  logic [SAMPLE_BITS-1:0]      wdata_q;

  // output register
  logic                        out_valid_q;
  logic [CH_BITS-1:0]          out_ch_q;
  logic signed [SAMPLE_BITS-1:0] out_s_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      src_q      <= 1'b0;
      band_q     <= '0;
      pct_q      <= 1'b0;
      start_q    <= '0;
      start_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FILTER_MODE:  mode_q     <= cfg_data_i[2:0];
        REG_REF_SOURCE:   src_q      <= cfg_data_i[0];
        REG_BAND_WIDTH:   band_q     <= cfg_data_i[BAND_BITS-1:0];
        REG_BAND_PERCENT: pct_q      <= cfg_data_i[0];
        REG_START_VALUE:  start_q    <= signed'(cfg_data_i);
        REG_START_ENABLE: start_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign start_w     = SAMPLE_BITS'(start_q);
  assign mode_ok     = (mode_q <= 3'(MODE_IN_LE));
  assign inside_mode = (mode_q == 3'(MODE_IN_LT)) || (mode_q == 3'(MODE_IN_LE));
  // reference written only on pass: a younger sample must wait for the verdict
  assign late_mode   = mode_ok && (mode_q >= 3'(MODE_OUT_GE)) && !src_q;

  assign band_cfg.percent = pct_q;
  assign band_cfg.width   = band_q;

  // input side
  assign in_idx    = channel_i[IDX_BITS-1:0];
  assign in_range  = ({1'b0, channel_i} < (CH_BITS+1)'(CHANNELS));
  assign hazard    = late_mode && ((v1_q && (ch1_q == channel_i)) ||
                                   (v2_q && (ch2_q == channel_i)) ||
                                   (v3_q && (ch3_q == channel_i)));
  assign advance   = !(out_valid_q && !out_ready_i && v3_q && pass3);
  assign in_ready_o = advance && !hazard;
  assign accept    = in_valid_i && in_ready_o;
  assign live      = accept && in_range && mode_ok;
  assign was_valid = valid_q[in_idx];
  assign preload   = !was_valid && inside_mode && start_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (live) begin
      valid_q[in_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      ref_mem[ch3_q[IDX_BITS-1:0]] <= wdata;
    end
    if (advance) begin
      rd_q <= ref_mem[in_idx];
    end
  end

  // stage 1: pick the reference, form distance and magnitude
  always_comb begin
    priority if (v2_q && (ch2_q == ch1_q)) begin
      fwd1 = s2_q;
    end else if (v3_q && (ch3_q == ch1_q)) begin
      fwd1 = s3_q;
    end else if (wv_q && (wch_q == ch1_q)) begin
      fwd1 = signed'(wdata_q);
    end else begin
      fwd1 = signed'(rd_q);
    end
  end

  assign ref1  = pre1_q ? start_w : fwd1;
  assign sx1   = DIFF_BITS'(s1_q);
  assign rx1   = DIFF_BITS'(ref1);
  assign diff1 = (sx1 >= rx1) ? unsigned'(sx1 - rx1) : unsigned'(rx1 - sx1);
  assign rabs1 = ref1[SAMPLE_BITS-1] ? unsigned'(-ref1) : unsigned'(ref1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      wv_q <= 1'b0;
    end else if (advance) begin
      v1_q <= live;
      v2_q <= v1_q;
      v3_q <= v2_q;
      wv_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ch1_q    <= channel_i;
      s1_q     <= sample_i;
      first1_q <= !was_valid && !preload;
      pre1_q   <= preload;

      ch2_q    <= ch1_q;
      s2_q     <= s1_q;
      first2_q <= first1_q;
      pre2_q   <= pre1_q;
      zero2_q  <= (diff1 == '0);
      diff2_q  <= diff1;
      rabs2_q  <= rabs1;

      ch3_q    <= ch2_q;
      s3_q     <= s2_q;
      first3_q <= first2_q;
      pre3_q   <= pre2_q;
      zero3_q  <= zero2_q;

      wch_q    <= ch3_q;
      wdata_q  <= wdata;
    end
  end

  drbe_band u_band (
    .clk_i      (clk_i),
    .en_i       (advance),
    .band_cfg_i (band_cfg),
    .diff_i     (diff2_q),
    .ref_abs_i  (rabs2_q),
    .cmp_o      (cmp3)
  );

  // stage 3: verdict and write-back
  always_comb begin
    if (first3_q) begin
      pass3 = (mode_q != 3'(MODE_CHANGE_QUIET));
    end else begin
      unique case (mode_q)
        MODE_CHANGE, MODE_CHANGE_QUIET: pass3 = !zero3_q;
        MODE_OUT_GE:                    pass3 = !cmp3.lt;
        MODE_OUT_GT:                    pass3 = cmp3.gt;
        MODE_IN_LT:                     pass3 = cmp3.lt;
        MODE_IN_LE:                     pass3 = !cmp3.gt;
        default:                        pass3 = 1'b0;
      endcase
    end
  end

  // a blocked preloaded channel still has to hold the start value
  assign we    = advance && v3_q && (first3_q || pass3 || !late_mode || pre3_q);
  assign wdata = (first3_q || pass3 || !late_mode) ? unsigned'(s3_q) : unsigned'(start_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && v3_q && pass3) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && v3_q && pass3) begin
      out_ch_q <= ch3_q;
      out_s_q  <= s3_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign out_sample_o  = out_s_q;

endmodule
